### design/mmf_pkg.sv
`default_nettype none

package mmf_pkg;

   // Line store geometry
   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = $clog2(MAX_WIDTH);

   // Register field widths
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 16;
   localparam int ROW_W    = 16;

   // Common width for column compares against the frame width
   localparam int EXT_W = (ADDR_W + 1 > WIDTH_W) ? ADDR_W + 1 : WIDTH_W;

   // Pixel and window geometry
   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = 3;
   localparam int PIX_W    = CHAN_W * NUM_CHAN;
   localparam int WIN_DIM  = 3;
   localparam int WIN_TAPS = WIN_DIM * WIN_DIM;
   localparam int WIN_CTR  = WIN_TAPS / 2;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SELECT_MAX   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COLOUR_MODE  = 2'd3;

   // Register reset values
   localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd1024;
   localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd1;

   // Input action codes
   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_DRAIN = 1'b1;

   // Reduction seeds
   localparam logic [CHAN_W-1:0] SEED_MIN = 8'd255;
   localparam logic [CHAN_W-1:0] SEED_MAX = 8'd0;

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic              action;
      logic [CHAN_W-1:0] in_red;
      logic [CHAN_W-1:0] in_green;
      logic [CHAN_W-1:0] in_blue;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic              frame_last;
   } rsp_payload_type;

   // Per-item control that travels alongside the window
   typedef struct packed {
      logic                emit;
      logic                last;
      logic [WIN_TAPS-1:0] mask;
   } win_ctrl_type;

   // Saturating row increment
   function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
      row_inc = (r == '1) ? r : r + ROW_W'(1);
   endfunction

endpackage

`default_nettype wire

### design/mmf_line_buf.sv
`default_nettype none

module mmf_line_buf (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        acc_valid,
   input  wire logic [mmf_pkg::ADDR_W-1:0]  acc_addr,
   input  wire logic [mmf_pkg::PIX_W-1:0]   acc_sample,
   output logic      [mmf_pkg::PIX_W-1:0]   up_px,
   output logic      [mmf_pkg::PIX_W-1:0]   mid_px
);

   logic [mmf_pkg::PIX_W-1:0]  upper_mem [mmf_pkg::MAX_WIDTH];
   logic [mmf_pkg::PIX_W-1:0]  middle_mem [mmf_pkg::MAX_WIDTH];

   logic [mmf_pkg::PIX_W-1:0]  up_rd_ff;
   logic [mmf_pkg::PIX_W-1:0]  mid_rd_ff;
   logic                       p_valid_ff;
   logic [mmf_pkg::ADDR_W-1:0] p_addr_ff;
   logic                       fwd_ff;
   logic                       fwd_in;
   logic [mmf_pkg::PIX_W-1:0]  fwd_data_ff;

   // Previous transaction writes the upper row at the same edge we read it
   assign fwd_in = p_valid_ff && (p_addr_ff == acc_addr);

   // Upper row: read on accept, write back the old middle in the cycle after
   always_ff @(posedge clock) begin
      if (acc_valid) begin
         up_rd_ff <= upper_mem[acc_addr];
      end
      if (p_valid_ff) begin
         upper_mem[p_addr_ff] <= mid_rd_ff;
      end
   end

   // Middle row: read old value and store the new sample on accept
   always_ff @(posedge clock) begin
      if (acc_valid) begin
         mid_rd_ff                <= middle_mem[acc_addr];
         middle_mem[acc_addr]     <= acc_sample;
      end
   end

   // Track the pending upper write and its bypass
   always_ff @(posedge clock) begin
      if (acc_valid) begin
         p_addr_ff   <= acc_addr;
         fwd_ff      <= fwd_in;
         fwd_data_ff <= mid_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= acc_valid;
      end
   end

   assign up_px  = fwd_ff ? fwd_data_ff : up_rd_ff;
   assign mid_px = mid_rd_ff;

endmodule

`default_nettype wire

### design/mmf_lane.sv
`default_nettype none

module mmf_lane (
   input  wire logic                                              select_max,
   input  wire logic [mmf_pkg::WIN_TAPS-1:0][mmf_pkg::CHAN_W-1:0] tap_px,
   input  wire logic [mmf_pkg::WIN_TAPS-1:0]                      tap_mask,
   output logic      [mmf_pkg::CHAN_W-1:0]                        result_px
);

   logic [mmf_pkg::CHAN_W-1:0] seed;
   logic [mmf_pkg::CHAN_W-1:0] lvl0 [8];
   logic [mmf_pkg::CHAN_W-1:0] lvl1 [4];
   logic [mmf_pkg::CHAN_W-1:0] lvl2 [2];

   function automatic logic [mmf_pkg::CHAN_W-1:0] pick(
      input logic                       sel_max,
      input logic [mmf_pkg::CHAN_W-1:0] a,
      input logic [mmf_pkg::CHAN_W-1:0] b
   );
      if (sel_max) begin
         pick = (a > b) ? a : b;
      end else begin
         pick = (a < b) ? a : b;
      end
   endfunction

   assign seed = select_max ? mmf_pkg::SEED_MAX : mmf_pkg::SEED_MIN;

   // Replace masked neighbors with the seed, skip the center tap
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         if (i < mmf_pkg::WIN_CTR) begin
            lvl0[i] = tap_mask[i] ? tap_px[i] : seed;
         end else begin
            lvl0[i] = tap_mask[i+1] ? tap_px[i+1] : seed;
         end
      end
   end

   // Reduce the eight neighbors in a three-level tree
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lvl1[i] = pick(select_max, lvl0[2*i], lvl0[2*i+1]);
      end
      for (int i = 0; i < 2; i++) begin
         lvl2[i] = pick(select_max, lvl1[2*i], lvl1[2*i+1]);
      end
   end

   assign result_px = pick(select_max, lvl2[0], lvl2[1]);

endmodule

`default_nettype wire

### design/mmf_out_fifo.sv
`default_nettype none

module mmf_out_fifo (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   input  wire mmf_pkg::rsp_payload_type           push_data,
   input  wire logic                               pop,
   output logic                                    out_valid,
   output mmf_pkg::rsp_payload_type                out_data,
   output logic      [mmf_pkg::FIFO_CNT_W-1:0]     count
);

   mmf_pkg::rsp_payload_type          mem_ff [mmf_pkg::FIFO_DEPTH];
   logic [mmf_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff;
   logic [mmf_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff;
   logic [mmf_pkg::FIFO_CNT_W-1:0]    count_ff;

   // Store incoming result transactions
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + mmf_pkg::FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + mmf_pkg::FIFO_PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + mmf_pkg::FIFO_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - mmf_pkg::FIFO_CNT_W'(1);
         end
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

`default_nettype wire

### design/morph_3x3_min_max_filter.sv
`default_nettype none

// 3x3 neighbor minimum/maximum filter on a raster pixel stream. Takes one pixel
// transaction per clock and sustains one result per clock while the result side
// does not stall. Each result is, per channel, the min (select_max=0) or max
// (select_max=1) of the up to eight in-image neighbors, center excluded. Results
// trail their inputs by one row plus one pixel, so feed frame_width+1 drain
// transactions (action=1) after the last pixel to flush a frame; frame_last marks
// its final result. Two line stores of MAX_WIDTH pixels feed a 3x3 window; three
// channel lanes reduce it and a four-entry result queue decouples the output.
// A result passes the p1 and p2 pipeline registers and the result queue before it is
// offered; req_stall rises only when the result queue plus in-flight results would
// fill it. Write configuration only while the block is idle.
module morph_3x3_min_max_filter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire mmf_pkg::req_payload_type            req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output mmf_pkg::rsp_payload_type                 rsp_payload,
   input  wire logic                                csr_wr_en,
   input  wire logic [mmf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mmf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Configuration registers
   logic [mmf_pkg::WIDTH_W-1:0]  frame_width_ff;
   logic [mmf_pkg::HEIGHT_W-1:0] frame_height_ff;
   logic                         select_max_ff;
   logic                         colour_mode_ff;

   // Stream counters
   logic [mmf_pkg::ROW_W-1:0]  in_row_ff,  in_row_in;
   logic [mmf_pkg::ADDR_W-1:0] in_col_ff,  in_col_in;
   logic [mmf_pkg::ROW_W-1:0]  out_row_ff, out_row_in;
   logic [mmf_pkg::ADDR_W-1:0] out_col_ff, out_col_in;

   logic [mmf_pkg::EXT_W-1:0]    w_eff;
   logic [mmf_pkg::HEIGHT_W-1:0] h_eff;

   logic [mmf_pkg::ROW_W-1:0]  in_row_p,  out_row_p;
   logic [mmf_pkg::ADDR_W-1:0] in_col_p,  out_col_p;
   logic [mmf_pkg::EXT_W-1:0]  in_col_inc, out_col_inc;
   logic [mmf_pkg::WIN_DIM-1:0] row_ok, col_ok;

   logic                      req_accept;
   logic [mmf_pkg::PIX_W-1:0] sample;
   mmf_pkg::win_ctrl_type     ctrl_in;

   // Pipeline
   logic                      p1_valid_ff;
   mmf_pkg::win_ctrl_type     p1_ctrl_ff;
   logic [mmf_pkg::PIX_W-1:0] p1_sample_ff;
   logic                      p2_valid_ff;
   mmf_pkg::win_ctrl_type     p2_ctrl_ff;
   logic [mmf_pkg::PIX_W-1:0] win_ff [mmf_pkg::WIN_DIM][mmf_pkg::WIN_DIM];

   logic [mmf_pkg::PIX_W-1:0] up_px, mid_px;
   logic [mmf_pkg::CHAN_W-1:0] lane_px [mmf_pkg::NUM_CHAN];

   mmf_pkg::rsp_payload_type        rsp_in;
   logic                            push;
   logic                            pop;
   logic [mmf_pkg::FIFO_CNT_W-1:0]  fifo_count;
   logic [mmf_pkg::FIFO_CNT_W:0]    credit_used;

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= mmf_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= mmf_pkg::FRAME_HEIGHT_RST;
         select_max_ff   <= 1'b0;
         colour_mode_ff  <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            mmf_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[mmf_pkg::WIDTH_W-1:0];
            end
            mmf_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[mmf_pkg::HEIGHT_W-1:0];
            end
            mmf_pkg::REG_SELECT_MAX: begin
               select_max_ff <= csr_wdata[0];
            end
            mmf_pkg::REG_COLOUR_MODE: begin
               colour_mode_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Clamp frame dimensions to their legal range
   always_comb begin
      w_eff = mmf_pkg::EXT_W'(frame_width_ff);
      if (frame_width_ff == '0) begin
         w_eff = mmf_pkg::EXT_W'(1);
      end else if (w_eff > mmf_pkg::EXT_W'(mmf_pkg::MAX_WIDTH)) begin
         w_eff = mmf_pkg::EXT_W'(mmf_pkg::MAX_WIDTH);
      end
      h_eff = (frame_height_ff == '0) ? mmf_pkg::HEIGHT_W'(1) : frame_height_ff;
   end

   // Resolve counters, masks and next counter values for the incoming transaction
   always_comb begin
      in_row_p  = in_row_ff;
      in_col_p  = in_col_ff;
      out_row_p = out_row_ff;
      out_col_p = out_col_ff;
      if (mmf_pkg::EXT_W'(in_col_ff) >= w_eff) begin
         in_col_p = '0;
         in_row_p = mmf_pkg::row_inc(in_row_ff);
      end
      if (mmf_pkg::EXT_W'(out_col_ff) >= w_eff) begin
         out_col_p = '0;
         out_row_p = mmf_pkg::row_inc(out_row_ff);
      end

      ctrl_in.emit = (in_row_p >= mmf_pkg::ROW_W'(2)) ||
                     ((in_row_p == mmf_pkg::ROW_W'(1)) && (in_col_p != '0));
      ctrl_in.last = ctrl_in.emit &&
                     (out_row_p >= h_eff - mmf_pkg::HEIGHT_W'(1)) &&
                     (mmf_pkg::EXT_W'(out_col_p) >= w_eff - mmf_pkg::EXT_W'(1));

      row_ok[0] = (out_row_p != '0);
      row_ok[1] = (out_row_p < h_eff);
      row_ok[2] = ({1'b0, out_row_p} + (mmf_pkg::ROW_W+1)'(1)) < {1'b0, h_eff};
      col_ok[0] = (out_col_p != '0);
      col_ok[1] = (mmf_pkg::EXT_W'(out_col_p) < w_eff);
      col_ok[2] = (mmf_pkg::EXT_W'(out_col_p) + mmf_pkg::EXT_W'(1)) < w_eff;
      for (int a = 0; a < mmf_pkg::WIN_DIM; a++) begin
         for (int b = 0; b < mmf_pkg::WIN_DIM; b++) begin
            ctrl_in.mask[a*mmf_pkg::WIN_DIM+b] = row_ok[a] && col_ok[b];
         end
      end
      ctrl_in.mask[mmf_pkg::WIN_CTR] = 1'b0;

      // Advance the output position on emitted results
      out_row_in  = out_row_p;
      out_col_in  = out_col_p;
      out_col_inc = mmf_pkg::EXT_W'(out_col_p) + mmf_pkg::EXT_W'(1);
      if (ctrl_in.emit) begin
         if (out_col_inc >= w_eff) begin
            out_col_in = '0;
            out_row_in = mmf_pkg::row_inc(out_row_p);
         end else begin
            out_col_in = out_col_inc[mmf_pkg::ADDR_W-1:0];
         end
      end

      // Advance the input position on every transaction
      in_row_in  = in_row_p;
      in_col_inc = mmf_pkg::EXT_W'(in_col_p) + mmf_pkg::EXT_W'(1);
      if (in_col_inc >= w_eff) begin
         in_col_in = '0;
         in_row_in = mmf_pkg::row_inc(in_row_p);
      end else begin
         in_col_in = in_col_inc[mmf_pkg::ADDR_W-1:0];
      end

      // Restart the frame after its final result
      if (ctrl_in.last) begin
         in_row_in  = '0;
         in_col_in  = '0;
         out_row_in = '0;
         out_col_in = '0;
      end
   end

   assign req_accept = req_valid && !req_stall;

   // Drain transactions stand in for a zero pixel
   assign sample = (req_payload.action == mmf_pkg::ACTION_DRAIN) ? '0 :
                   {req_payload.in_blue, req_payload.in_green, req_payload.in_red};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else if (req_accept) begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

   // Line stores feed the upper and middle window rows
   mmf_line_buf u_line_buf (
      .clock      (clock),
      .reset      (reset),
      .acc_valid  (req_accept),
      .acc_addr   (in_col_p),
      .acc_sample (sample),
      .up_px      (up_px),
      .mid_px     (mid_px)
   );

   // Hold the transaction while the line stores are read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         p1_ctrl_ff   <= ctrl_in;
         p1_sample_ff <= sample;
      end
      if (p1_valid_ff) begin
         p2_ctrl_ff <= p1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= req_accept;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   // Shift the window by one column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < mmf_pkg::WIN_DIM; a++) begin
            for (int b = 0; b < mmf_pkg::WIN_DIM; b++) begin
               win_ff[a][b] <= '0;
            end
         end
      end else if (p1_valid_ff) begin
         for (int a = 0; a < mmf_pkg::WIN_DIM; a++) begin
            for (int b = 0; b < mmf_pkg::WIN_DIM - 1; b++) begin
               win_ff[a][b] <= win_ff[a][b+1];
            end
         end
         win_ff[0][mmf_pkg::WIN_DIM-1] <= up_px;
         win_ff[1][mmf_pkg::WIN_DIM-1] <= mid_px;
         win_ff[2][mmf_pkg::WIN_DIM-1] <= p1_sample_ff;
      end
   end

   // One reduction lane per channel
   for (genvar ch = 0; ch < mmf_pkg::NUM_CHAN; ch++) begin : g_lane
      logic [mmf_pkg::WIN_TAPS-1:0][mmf_pkg::CHAN_W-1:0] taps;

      for (genvar t = 0; t < mmf_pkg::WIN_TAPS; t++) begin : g_tap
         assign taps[t] =
            win_ff[t / mmf_pkg::WIN_DIM][t % mmf_pkg::WIN_DIM]
                  [ch*mmf_pkg::CHAN_W +: mmf_pkg::CHAN_W];
      end

      mmf_lane u_lane (
         .select_max (select_max_ff),
         .tap_px     (taps),
         .tap_mask   (p2_ctrl_ff.mask),
         .result_px  (lane_px[ch])
      );
   end

   // Merge lane results into one result transaction; green and blue are zero in gray mode
   always_comb begin
      rsp_in.out_red    = lane_px[0];
      rsp_in.out_green  = colour_mode_ff ? lane_px[1] : '0;
      rsp_in.out_blue   = colour_mode_ff ? lane_px[2] : '0;
      rsp_in.frame_last = p2_ctrl_ff.last;
   end

   assign push = p2_valid_ff && p2_ctrl_ff.emit;
   assign pop  = rsp_valid && !rsp_stall;

   mmf_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (rsp_in),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload),
      .count     (fifo_count)
   );

   // Reserve queue space for every result still in the pipeline
   assign credit_used = (mmf_pkg::FIFO_CNT_W+1)'(fifo_count) +
                        (mmf_pkg::FIFO_CNT_W+1)'(p1_valid_ff && p1_ctrl_ff.emit) +
                        (mmf_pkg::FIFO_CNT_W+1)'(p2_valid_ff && p2_ctrl_ff.emit);
   assign req_stall = (credit_used >= (mmf_pkg::FIFO_CNT_W+1)'(mmf_pkg::FIFO_DEPTH));

endmodule

`default_nettype wire

### dv/morph_3x3_min_max_filter_tb.sv
`timescale 1ns / 1ps

module morph_3x3_min_max_filter_tb;

   localparam int RANDOM_ITEMS   = 600;
   localparam int FILL_WIDTH     = 48;
   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_pattern_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   mmf_pkg::req_payload_type          req_payload = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   mmf_pkg::rsp_payload_type          rsp_payload;
   logic                              csr_wr_en = 1'b0;
   logic [mmf_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [mmf_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   morph_3x3_min_max_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Pixel stream and filtered pixels still owed by the block
   mmf_pkg::req_payload_type pixels_to_send[$];
   mmf_pkg::rsp_payload_type filtered_pixels_due[$];
   mmf_pkg::rsp_payload_type oldest_due;

   int unsigned pixels_accepted = 0;
   int unsigned pixels_checked  = 0;
   int unsigned frames_closed   = 0;
   int unsigned mismatch_count  = 0;
   int unsigned quiet_cycles    = 0;

   // Filter state mirrored for prediction
   logic [mmf_pkg::PIX_W-1:0]    line_upper  [mmf_pkg::MAX_WIDTH];
   logic [mmf_pkg::PIX_W-1:0]    line_middle [mmf_pkg::MAX_WIDTH];
   logic [mmf_pkg::PIX_W-1:0]    win [mmf_pkg::WIN_DIM][mmf_pkg::WIN_DIM];
   logic [mmf_pkg::ROW_W-1:0]    in_row  = '0;
   logic [mmf_pkg::ROW_W-1:0]    out_row = '0;
   logic [mmf_pkg::EXT_W-1:0]    in_col  = '0;
   logic [mmf_pkg::EXT_W-1:0]    out_col = '0;
   logic [mmf_pkg::WIDTH_W-1:0]  cfg_width  = mmf_pkg::FRAME_WIDTH_RST;
   logic [mmf_pkg::HEIGHT_W-1:0] cfg_height = mmf_pkg::FRAME_HEIGHT_RST;
   bit                           cfg_select_max = 1'b0;
   bit                           cfg_color_mode = 1'b0;

   initial begin
      for (int i = 0; i < mmf_pkg::MAX_WIDTH; i++) begin
         line_upper[i]  = '0;
         line_middle[i] = '0;
      end
      for (int i = 0; i < mmf_pkg::WIN_DIM; i++) begin
         for (int j = 0; j < mmf_pkg::WIN_DIM; j++) begin
            win[i][j] = '0;
         end
      end
   end

   function automatic int unsigned active_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > mmf_pkg::MAX_WIDTH) return mmf_pkg::MAX_WIDTH;
      return int'(cfg_width);
   endfunction

   function automatic int unsigned active_height();
      return (cfg_height == 0) ? 1 : int'(cfg_height);
   endfunction

   function automatic logic [mmf_pkg::ROW_W-1:0] saturating_next_row(
      input logic [mmf_pkg::ROW_W-1:0] row
   );
      return (row == {mmf_pkg::ROW_W{1'b1}}) ? row : row + mmf_pkg::ROW_W'(1);
   endfunction

   function automatic bit frame_open();
      return (in_row != 0) || (in_col != 0) || (out_row != 0) || (out_col != 0);
   endfunction

   // Min or max over the in-image neighbors of one channel, center left out
   function automatic logic [mmf_pkg::CHAN_W-1:0] neighbor_extreme(input int lane,
                                                                   input int unsigned h,
                                                                   input int unsigned w);
      logic [mmf_pkg::CHAN_W-1:0] acc;
      logic [mmf_pkg::CHAN_W-1:0] v;
      int a;
      int b;
      int r;
      int c;
      acc = cfg_select_max ? mmf_pkg::SEED_MAX : mmf_pkg::SEED_MIN;
      for (a = 0; a < mmf_pkg::WIN_DIM; a++) begin
         for (b = 0; b < mmf_pkg::WIN_DIM; b++) begin
            if (a == 1 && b == 1) continue;
            if (a == 0 && out_row == 0) continue;
            if (b == 0 && out_col == 0) continue;
            r = int'(out_row) + a - 1;
            c = int'(out_col) + b - 1;
            if (a != 0 && r >= int'(h)) continue;
            if (b != 0 && c >= int'(w)) continue;
            v = win[a][b][lane*mmf_pkg::CHAN_W +: mmf_pkg::CHAN_W];
            if (cfg_select_max ? (v > acc) : (v < acc)) acc = v;
         end
      end
      return acc;
   endfunction

   // Advance the mirrored filter by one accepted transaction
   function automatic void advance_filter(input mmf_pkg::req_payload_type txn);
      int unsigned                w;
      int unsigned                h;
      int                         k;
      logic [mmf_pkg::PIX_W-1:0]  fresh;
      logic [mmf_pkg::PIX_W-1:0]  up;
      logic [mmf_pkg::PIX_W-1:0]  mid;
      logic [mmf_pkg::ADDR_W-1:0] col;
      bit                         emit;
      bit                         last;
      mmf_pkg::rsp_payload_type   res;
      w = active_width();
      h = active_height();
      last = 1'b0;
      if (in_col >= w) begin
         in_col = '0;
         in_row = saturating_next_row(in_row);
      end
      if (out_col >= w) begin
         out_col = '0;
         out_row = saturating_next_row(out_row);
      end
      fresh = (txn.action == mmf_pkg::ACTION_PIXEL) ?
              {txn.in_blue, txn.in_green, txn.in_red} : '0;
      col = in_col[mmf_pkg::ADDR_W-1:0];
      up  = line_upper[col];
      mid = line_middle[col];
      line_upper[col]  = mid;
      line_middle[col] = fresh;
      for (k = 0; k < mmf_pkg::WIN_DIM; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = up;
      win[1][2] = mid;
      win[2][2] = fresh;

      emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      if (emit) begin
         res.out_red   = neighbor_extreme(0, h, w);
         res.out_green = cfg_color_mode ? neighbor_extreme(1, h, w) : '0;
         res.out_blue  = cfg_color_mode ? neighbor_extreme(2, h, w) : '0;
         last = (out_row >= h - 1) && (out_col >= w - 1);
         res.frame_last = last;
         filtered_pixels_due.push_back(res);
         out_col++;
         if (out_col >= w) begin
            out_col = '0;
            out_row = saturating_next_row(out_row);
         end
      end

      in_col++;
      if (in_col >= w) begin
         in_col = '0;
         in_row = saturating_next_row(in_row);
      end

      // Frame done: next transaction opens a new frame
      if (last) begin
         in_row  = '0;
         in_col  = '0;
         out_row = '0;
         out_col = '0;
      end
   endfunction

   // Driver: bursts of random length separated by random gaps
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_filter(req_payload);
            pixels_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixels_to_send.size() != 0) begin
               req_valid   <= 1'b1;
               req_payload <= pixels_to_send.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 64);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(input string name,
                                       input logic [mmf_pkg::CHAN_W-1:0] want,
                                       input logic [mmf_pkg::CHAN_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Monitor and result-side stall pattern
   stall_pattern_type stall_pattern  = STALL_NONE;
   int unsigned       pattern_cycles = 0;
   int unsigned       hold_left      = 0;
   bit                hold_wanted    = 1'b0;
   bit                hold_served    = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (filtered_pixels_due.size() == 0) begin
               $error("filtered pixel %h arrived with none outstanding", rsp_payload);
               mismatch_count++;
            end else begin
               oldest_due = filtered_pixels_due.pop_front();
               check_field("out_red", oldest_due.out_red, rsp_payload.out_red);
               check_field("out_green", oldest_due.out_green, rsp_payload.out_green);
               check_field("out_blue", oldest_due.out_blue, rsp_payload.out_blue);
               check_field("frame_last", mmf_pkg::CHAN_W'(oldest_due.frame_last),
                           mmf_pkg::CHAN_W'(rsp_payload.frame_last));
               pixels_checked++;
            end
            if (rsp_payload.frame_last === 1'b1) frames_closed++;
         end

         // Switch the stall pattern now and then
         pattern_cycles++;
         if (pattern_cycles >= 200) begin
            pattern_cycles = 0;
            stall_pattern  = stall_pattern_type'($urandom_range(0, 3));
         end

         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_wanted && !hold_served) begin
            // Long hold-off: let the block fill up and push back on its input
            hold_served = 1'b1;
            hold_left   = LONG_HOLD - 1;
            rsp_stall  <= 1'b1;
         end else begin
            case (stall_pattern)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= (pattern_cycles % 3 == 0);
            endcase
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $error("no transaction for %0d cycles", quiet_cycles);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [mmf_pkg::CHAN_W-1:0] random_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return mmf_pkg::CHAN_W'($urandom);
      endcase
   endfunction

   function automatic mmf_pkg::req_payload_type random_item(input int unsigned drain_odds);
      mmf_pkg::req_payload_type txn;
      txn.action   = ($urandom_range(1, 100) <= drain_odds) ?
                     mmf_pkg::ACTION_DRAIN : mmf_pkg::ACTION_PIXEL;
      txn.in_red   = random_sample();
      txn.in_green = random_sample();
      txn.in_blue  = random_sample();
      return txn;
   endfunction

   function automatic void queue_item(input logic action,
                                      input logic [mmf_pkg::PIX_W-1:0] rgb);
      mmf_pkg::req_payload_type txn;
      txn.action   = action;
      txn.in_red   = rgb[mmf_pkg::CHAN_W-1:0];
      txn.in_green = rgb[2*mmf_pkg::CHAN_W-1:mmf_pkg::CHAN_W];
      txn.in_blue  = rgb[3*mmf_pkg::CHAN_W-1:2*mmf_pkg::CHAN_W];
      pixels_to_send.push_back(txn);
   endfunction

   // Drain transactions that flush the last row plus one pixel
   function automatic void queue_flush();
      int unsigned i;
      for (i = 0; i <= active_width(); i++) begin
         queue_item(mmf_pkg::ACTION_DRAIN, mmf_pkg::PIX_W'($urandom));
      end
   endfunction

   function automatic int unsigned queue_frame(input int unsigned drain_odds);
      int unsigned count;
      int unsigned i;
      count = active_width() * active_height();
      for (i = 0; i < count; i++) begin
         pixels_to_send.push_back(random_item(drain_odds));
      end
      queue_flush();
      return count + active_width() + 1;
   endfunction

   task automatic wait_sent();
      do @(negedge clock); while (pixels_to_send.size() != 0 || req_valid);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pixels_to_send.size() != 0 || req_valid || filtered_pixels_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [mmf_pkg::CSR_IDX_W-1:0] reg_index,
                            input logic [mmf_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= value;
   endtask

   task automatic configure(input int unsigned width, input int unsigned height,
                            input bit take_max, input bit color);
      wait_idle();
      csr_write(mmf_pkg::REG_FRAME_WIDTH, mmf_pkg::CSR_DATA_W'(width));
      csr_write(mmf_pkg::REG_FRAME_HEIGHT, mmf_pkg::CSR_DATA_W'(height));
      csr_write(mmf_pkg::REG_SELECT_MAX, mmf_pkg::CSR_DATA_W'(take_max));
      csr_write(mmf_pkg::REG_COLOUR_MODE, mmf_pkg::CSR_DATA_W'(color));
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_width      = mmf_pkg::WIDTH_W'(width);
      cfg_height     = mmf_pkg::HEIGHT_W'(height);
      cfg_select_max = take_max;
      cfg_color_mode = color;
      @(negedge clock);
   endtask

   task automatic configure_random();
      int unsigned width;
      case ($urandom_range(0, 9))
         0:       width = 0;
         1:       width = $urandom_range(13, FILL_WIDTH);
         default: width = $urandom_range(1, 12);
      endcase
      configure(width, $urandom_range(0, 6), bit'($urandom_range(0, 1)),
                bit'($urandom_range(0, 1)));
   endtask

   // Feed transactions one at a time until the frame closes
   task automatic close_open_frame(output int unsigned sent);
      sent = 0;
      while (frame_open()) begin
         pixels_to_send.push_back(random_item(10));
         sent++;
         wait_sent();
      end
   endtask

   initial begin
      int unsigned random_sent;
      int unsigned partial;
      int unsigned closing;
      random_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Zero width and height act as a single pixel: only the seed comes out
      configure(0, 0, 1'b0, 1'b0);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'hE7C3A5);
      queue_flush();

      // 3x3 color max with extreme samples and a drain standing in the center
      configure(3, 3, 1'b1, 1'b1);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'h000000);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'hFFFFFF);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'h80FF00);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'h01007F);
      queue_item(mmf_pkg::ACTION_DRAIN, 24'hFFFFFF);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'hFF00FF);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'h563412);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'h7F8080);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'hFEFFFE);
      queue_flush();

      // 2x2 color min
      configure(2, 2, 1'b0, 1'b1);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'hFFFFFF);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'h000000);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'h7FFE01);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'hFF80FF);
      queue_flush();

      // Single pixel in max mode
      configure(1, 1, 1'b1, 1'b0);
      queue_item(mmf_pkg::ACTION_PIXEL, 24'h5A5A5A);
      queue_flush();

      // Two rows at the widest random width so both line stores hold pixels
      // for every column used later; hold off results mid-frame
      configure(FILL_WIDTH, 2, 1'b1, 1'b1);
      void'(queue_frame(0));
      do @(negedge clock); while (pixels_to_send.size() > 100);
      hold_wanted = 1'b1;

      // Register changes in the middle of a frame: shrink, then grow the width
      configure(8, 4, 1'b0, 1'b1);
      repeat (13) pixels_to_send.push_back(random_item(0));
      configure(5, 6, 1'b1, 1'b0);
      repeat (12) pixels_to_send.push_back(random_item(0));
      configure(10, 2, 1'b0, 1'b1);
      close_open_frame(closing);

      // Random frames, some broken off by a register change
      while (random_sent < RANDOM_ITEMS) begin
         configure_random();
         if ($urandom_range(0, 7) == 0) begin
            partial = $urandom_range(1, active_width() * (active_height() + 1));
            repeat (partial) pixels_to_send.push_back(random_item(8));
            random_sent += partial;
            configure_random();
            close_open_frame(closing);
            random_sent += closing;
         end else begin
            random_sent += queue_frame(6);
         end
      end

      wait_idle();
      $display("Run covered %0d frames: %0d transactions in, %0d filtered pixels checked.",
               frames_closed, pixels_accepted, pixels_checked);
      $display("Widths 1 to %0d, mid-frame register changes, min and max, gray and color.",
               FILL_WIDTH);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
